// ===== src/assert_macros.svh =====
// assertion macros for the frame checker
// XFPC_ASSERT uses the module's clk and rst_n
// XFPC_ASSERT_CLK takes the clock and the active-low reset explicitly
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define XFPC_ASSERT_CLK(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);
`define XFPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define XFPC_ASSERT_CLK(label, clock, reset_n, prop, msg)
`define XFPC_ASSERT(label, prop, msg)
`endif

`endif

// ===== src/xfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// xfpc_pkg
// Types and constants shared by the framed packet checker modules.
// ----------------------------------------------------------------------------
package xfpc_pkg;

    // frame layout
    localparam logic [7:0]  SYNC_FIRST      = 8'h24;   // '$'
    localparam logic [7:0]  SYNC_SECOND     = 8'h4B;   // 'K'
    localparam logic [15:0] FRAME_OVERHEAD  = 16'd6;
    localparam logic [15:0] LAST_POS_MIN    = FRAME_OVERHEAD - 16'd1;
    localparam logic [15:0] POS_MAX         = 16'hFFFF;

    // byte positions of the header fields
    localparam logic [15:0] POS_SYNC_FIRST  = 16'd0;
    localparam logic [15:0] POS_SYNC_SECOND = 16'd1;
    localparam logic [15:0] POS_LEN_LOW     = 16'd2;
    localparam logic [15:0] POS_LEN_HIGH    = 16'd3;
    localparam logic [15:0] POS_ID          = 16'd4;

    // verdict codes, in check priority order after valid
    typedef enum logic [2:0] {
        VERDICT_VALID        = 3'd0,
        VERDICT_TOO_SHORT    = 3'd1,
        VERDICT_BAD_SYNC     = 3'd2,
        VERDICT_LEN_MISMATCH = 3'd3,
        VERDICT_ZERO_ID      = 3'd4,
        VERDICT_BAD_CHECKSUM = 3'd5
    } verdict_t;

    // one input byte transfer
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } byte_item_t;

    // one verdict transfer
    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  message_id;
        logic [15:0] payload_length;
        logic [7:0]  checksum_seen;
    } result_item_t;

endpackage

// ===== src/xfpc_byte_if.sv =====
// ----------------------------------------------------------------------------
// xfpc_byte_if
// Byte stream channel: valid/ready handshake with one frame byte per transfer.
// ----------------------------------------------------------------------------
interface xfpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== src/xfpc_result_if.sv =====
// ----------------------------------------------------------------------------
// xfpc_result_if
// Verdict channel: valid/ready handshake with one frame verdict per transfer.
// ----------------------------------------------------------------------------
interface xfpc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
    logic [7:0]  checksum_seen;

    modport source (output valid, output verdict, output message_id,
                    output payload_length, output checksum_seen, input ready);
    modport sink   (input valid, input verdict, input message_id,
                    input payload_length, input checksum_seen, output ready);
endinterface

// ===== src/xfpc_in_stage.sv =====
// ----------------------------------------------------------------------------
// xfpc_in_stage
// Input register: holds one accepted byte until the frame tracker consumes it.
// ----------------------------------------------------------------------------
module xfpc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  xfpc_pkg::byte_item_t in_data,
    output logic                 hold_valid,
    output xfpc_pkg::byte_item_t hold_data,
    input  logic                 take
);

    logic                 valid_reg;
    logic                 valid_next;
    xfpc_pkg::byte_item_t data_reg;

    // room when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded on each transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

// ===== src/xfpc_frame_track.sv =====
// ----------------------------------------------------------------------------
// xfpc_frame_track
// Frame state: byte position, sync flag, header capture and running XOR.
// Works out the verdict for the byte being consumed in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xfpc_frame_track (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  xfpc_pkg::byte_item_t   cur,
    output xfpc_pkg::result_item_t result
);

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic        sync_bad_reg;
    logic        sync_bad_next;
    logic [7:0]  len_low_reg;
    logic [7:0]  len_low_next;
    logic [7:0]  len_high_reg;
    logic [7:0]  len_high_next;
    logic [7:0]  id_reg;
    logic [7:0]  id_next;
    logic [7:0]  xor_reg;
    logic [7:0]  xor_next;

    logic [7:0]  b;
    logic [15:0] len_cur;
    logic [7:0]  xor_base;
    logic        in_coverage;
    xfpc_pkg::verdict_t verdict_cur;

    assign b = cur.frame_byte;

    // header capture, including the byte now being consumed
    always_comb
    begin
        sync_bad_next = sync_bad_reg
            || ((pos_reg == xfpc_pkg::POS_SYNC_FIRST)  && (b != xfpc_pkg::SYNC_FIRST))
            || ((pos_reg == xfpc_pkg::POS_SYNC_SECOND) && (b != xfpc_pkg::SYNC_SECOND));
        len_low_next  = (pos_reg == xfpc_pkg::POS_LEN_LOW)  ? b : len_low_reg;
        len_high_next = (pos_reg == xfpc_pkg::POS_LEN_HIGH) ? b : len_high_reg;
        id_next       = (pos_reg == xfpc_pkg::POS_ID)       ? b : id_reg;
    end

    assign len_cur = {len_high_next, len_low_next};

    // running xor: restarted from the length bytes once both are in
    always_comb
    begin
        if (pos_reg == xfpc_pkg::POS_LEN_HIGH)
        begin
            xor_base = ((len_cur >= 16'd1) ? len_low_next : 8'h00)
                     ^ ((len_cur >= 16'd2) ? len_high_next : 8'h00);
        end
        else
        begin
            xor_base = xor_reg;
        end
        in_coverage = (pos_reg >= xfpc_pkg::POS_ID)
                   && ({1'b0, pos_reg} < ({1'b0, len_cur} + 17'd2));
        xor_next    = in_coverage ? (xor_base ^ b) : xor_base;
    end

    // checks in priority order
    always_comb
    begin
        if (pos_reg < xfpc_pkg::LAST_POS_MIN)
        begin
            verdict_cur = xfpc_pkg::VERDICT_TOO_SHORT;
        end
        else if (sync_bad_next)
        begin
            verdict_cur = xfpc_pkg::VERDICT_BAD_SYNC;
        end
        else if ((pos_reg == xfpc_pkg::POS_MAX)
              || ((pos_reg - xfpc_pkg::LAST_POS_MIN) != len_cur))
        begin
            verdict_cur = xfpc_pkg::VERDICT_LEN_MISMATCH;
        end
        else if (id_next == 8'h00)
        begin
            verdict_cur = xfpc_pkg::VERDICT_ZERO_ID;
        end
        else if (xor_next != b)
        begin
            verdict_cur = xfpc_pkg::VERDICT_BAD_CHECKSUM;
        end
        else
        begin
            verdict_cur = xfpc_pkg::VERDICT_VALID;
        end
    end

    assign result.verdict        = verdict_cur;
    assign result.message_id     = id_next;
    assign result.payload_length = len_cur;
    assign result.checksum_seen  = b;

    // saturating position
    assign pos_next = (pos_reg == xfpc_pkg::POS_MAX) ? pos_reg : (pos_reg + 16'd1);

    // frame state, cleared after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sync_bad_reg <= 1'b0;
            len_low_reg  <= '0;
            len_high_reg <= '0;
            id_reg       <= '0;
            xor_reg      <= '0;
        end
        else if (step)
        begin
            if (cur.frame_end)
            begin
                pos_reg      <= '0;
                sync_bad_reg <= 1'b0;
                len_low_reg  <= '0;
                len_high_reg <= '0;
                id_reg       <= '0;
                xor_reg      <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                sync_bad_reg <= sync_bad_next;
                len_low_reg  <= len_low_next;
                len_high_reg <= len_high_next;
                id_reg       <= id_next;
                xor_reg      <= xor_next;
            end
        end
    end

    `XFPC_ASSERT(a_pos_clears_after_end, step && cur.frame_end |=> pos_reg == 16'd0, "position not cleared after last byte")
    `XFPC_ASSERT(a_pos_advances, step && !cur.frame_end && (pos_reg != xfpc_pkg::POS_MAX) |=> pos_reg == $past(pos_reg) + 16'd1, "position did not advance")
    `XFPC_ASSERT(a_sync_flag_needs_byte, sync_bad_reg |-> pos_reg != 16'd0, "sync flag set at frame start")

endmodule

// ===== src/xfpc_out_reg.sv =====
// ----------------------------------------------------------------------------
// xfpc_out_reg
// Result register: holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module xfpc_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  xfpc_pkg::result_item_t load_data,
    output logic                   free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output xfpc_pkg::result_item_t out_data
);

    logic                   valid_reg;
    logic                   valid_next;
    xfpc_pkg::result_item_t data_reg;

    // slot can take a new verdict when empty or being emptied
    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/xor_framed_packet_checker_unit.sv =====
// ----------------------------------------------------------------------------
// xor_framed_packet_checker_unit
// Byte-serial checker for '$' 'K' framed packets with an XOR checksum.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the frame channel, with frame_end on the last
// byte of each frame, and gives one verdict per frame on the result channel.
// A byte is accepted every cycle while results are taken; a byte waits only
// when it is a last byte and the result register still holds an untaken
// verdict. From the transfer of a last byte, its verdict passes through the
// input register and then the result register before it shows. The per-byte
// header capture, XOR update and check chain sit combinationally between
// these two registers.
`include "assert_macros.svh"

module xor_framed_packet_checker_unit (
    input  logic       clk,
    input  logic       rst_n,
    xfpc_byte_if.sink     frame,
    xfpc_result_if.source result
);

    xfpc_pkg::byte_item_t   in_data;
    xfpc_pkg::byte_item_t   hold_data;
    xfpc_pkg::result_item_t track_result;
    xfpc_pkg::result_item_t out_data;
    logic                   hold_valid;
    logic                   step;
    logic                   load;
    logic                   out_free;

    assign in_data.frame_byte = frame.frame_byte;
    assign in_data.frame_end  = frame.frame_end;

    // a byte leaves the input register unless it is a last byte with no room
    assign step = hold_valid && (!hold_data.frame_end || out_free);
    assign load = step && hold_data.frame_end;

    xfpc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (frame.valid),
        .in_ready   (frame.ready),
        .in_data    (in_data),
        .hold_valid (hold_valid),
        .hold_data  (hold_data),
        .take       (step)
    );

    xfpc_frame_track u_frame_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cur    (hold_data),
        .result (track_result)
    );

    xfpc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (track_result),
        .free      (out_free),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.verdict        = out_data.verdict;
    assign result.message_id     = out_data.message_id;
    assign result.payload_length = out_data.payload_length;
    assign result.checksum_seen  = out_data.checksum_seen;

    `XFPC_ASSERT(a_no_overwrite, result.valid && !result.ready |-> !load, "waiting verdict overwritten")
    `XFPC_ASSERT(a_valid_has_id, result.valid && (result.verdict == xfpc_pkg::VERDICT_VALID) |-> result.message_id != 8'h00, "valid verdict with zero id")
    `XFPC_ASSERT(a_stall_blocks_input, hold_valid && !step |-> !frame.ready, "input taken while stage stalled")

endmodule
